// ===== rtl/chained_hash_set_core_macros.svh =====
// Assertion macros for the hash set core
`ifndef CHAINED_HASH_SET_CORE_MACROS_SVH
`define CHAINED_HASH_SET_CORE_MACROS_SVH

// Implication checked every clock, off during reset
`define CHS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Property checked on the following clock
`define CHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/chs_pkg.sv =====
package chs_pkg;
	localparam int KEY_W = 31;
	localparam int CFG_W = 9;
	localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = 9'd7;

	typedef enum logic {
		KIND_FIND   = 1'b0,
		KIND_INSERT = 1'b1
	} kind_t;

	// request from sequencer to modulo unit
	typedef struct packed {
		logic                 go;
		logic [KEY_W-1:0]     key;
		logic [CFG_W-1:0]     divisor;
	} mod_req_t;
endpackage

// ===== rtl/chs_mod.sv =====
// Restoring remainder, one quotient bit per cycle
module chs_mod (
	input  logic                         clk,
	input  logic                         arst_n,
	input  chs_pkg::mod_req_t            req,
	output logic                         done,
	output logic [chs_pkg::CFG_W-1:0]    rem
);
	localparam int KW = chs_pkg::KEY_W;
	localparam int CW = chs_pkg::CFG_W;
	localparam int BW = $clog2(KW + 1);

	logic [KW-1:0]   key_q;
	logic [CW:0]     rem_q;
	logic [CW-1:0]   div_q;
	logic [BW-1:0]   cnt_q;
	logic            busy_q;
	logic [CW+1:0]   trial;

	assign trial = {rem_q, key_q[KW-1]} - {2'b00, div_q};
	assign rem = rem_q[CW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q <= BW'(KW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == BW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			key_q <= req.key;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			key_q <= {key_q[KW-2:0], 1'b0};
			if (!trial[CW+1])
				rem_q <= trial[CW:0];
			else
				rem_q <= {rem_q[CW-1:0], key_q[KW-1]};
		end
	end
endmodule

// ===== rtl/chained_hash_set_core.sv =====
// Sequence: bit-serial modulo of the key by the bucket count, then head read, decide and
//   result, plus a node read and a compare for each chain node walked.
// Throughput: one operation at a time; busy drops in the strobe cycle, so the next
//   start may transfer at the edge that takes the result. The receiver cannot stall.
// Reset: heads cleared by a pass over all BUCKETS entries (busy high); node pool empty.
//   A bucket_count write starts the same clearing pass.
module chained_hash_set_core #(
	parameter int BUCKETS = 256,
	parameter int NODES = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       kind,
	input  logic [chs_pkg::KEY_W-1:0]  key,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [chs_pkg::CFG_W-1:0]  cfg_data,
	output logic                       strobe,
	output logic                       found,
	output logic                       inserted,
	output logic                       full_res
);
	localparam int BA = $clog2(BUCKETS);
	localparam int NA = $clog2(NODES);
	localparam int NC = $clog2(NODES + 1);
	localparam int CW = chs_pkg::CFG_W;
	localparam int KW = chs_pkg::KEY_W;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_MOD, ST_HEAD, ST_NODE, ST_CMP, ST_DONE
	} state_t;

	state_t state_q;

	// head memory: {valid, index}; node memory: {key, link valid, link index}
	logic [NA:0]        head_mem [BUCKETS];
	logic [KW+NA:0]     node_mem [NODES];
	logic [NA:0]        head_rd;
	logic [KW+NA:0]     node_rd;

	logic [CW-1:0]      bcount_q;
	logic [NC-1:0]      used_q;
	logic [BA-1:0]      clr_q;
	logic [BA-1:0]      bkt_q;
	logic [KW-1:0]      key_q;
	logic               kind_q;
	logic [NA-1:0]      ptr_q;
	logic [NC-1:0]      steps_q;
	logic               hit_q;
	logic               cmp_wait_q;

	chs_pkg::mod_req_t  mreq;
	logic               mdone;
	logic [CW-1:0]      mrem;
	logic [CW-1:0]      eff;

	// saturate register to 1..BUCKETS
	always_comb begin
		eff = bcount_q;
		if (bcount_q == '0)
			eff = CW'(1);
		else if ({{(32-CW){1'b0}}, bcount_q} > 32'(BUCKETS))
			eff = CW'(BUCKETS);
	end

	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE) && !start;
	assign mreq.go = start && !busy;
	assign mreq.key = key;
	assign mreq.divisor = eff;

	chs_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.done   (mdone),
		.rem    (mrem)
	);

	// head memory: one read, one write per cycle
	logic           hwe;
	logic [BA-1:0]  hwa;
	logic [NA:0]    hwd;
	always_comb begin
		hwe = 1'b0;
		hwa = bkt_q;
		hwd = {1'b1, used_q[NA-1:0]};
		if (state_q == ST_CLEAR) begin
			hwe = 1'b1;
			hwa = clr_q;
			hwd = '0;
		end else if (state_q == ST_DONE && kind_q == chs_pkg::KIND_INSERT && !hit_q
				&& used_q < NC'(NODES)) begin
			hwe = 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (hwe)
			head_mem[hwa] <= hwd;
		head_rd <= head_mem[bkt_q];
	end

	// node memory: new node written with the old head as link
	logic nwe;
	assign nwe = (state_q == ST_DONE) && kind_q == chs_pkg::KIND_INSERT && !hit_q
		&& used_q < NC'(NODES);
	always_ff @(posedge clk) begin
		if (nwe)
			node_mem[used_q[NA-1:0]] <= {key_q, head_rd};
		node_rd <= node_mem[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			bcount_q <= chs_pkg::BUCKET_COUNT_RST;
			used_q <= '0;
			strobe <= 1'b0;
			found <= 1'b0;
			inserted <= 1'b0;
			full_res <= 1'b0;
		end else begin
			strobe <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BA'(BUCKETS - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_MOD;
					end else if (cfg_valid) begin
						bcount_q <= cfg_data;
						clr_q <= '0;
						state_q <= ST_CLEAR;
					end
				end
				ST_MOD: if (mdone) state_q <= ST_HEAD;
				ST_HEAD: state_q <= ST_NODE; // head_rd valid next cycle
				ST_NODE: begin
					// head_rd now valid: start walk
					if (head_rd[NA])
						state_q <= ST_CMP;
					else
						state_q <= ST_DONE;
				end
				ST_CMP: begin
					if (cmp_wait_q) begin
						state_q <= ST_CMP; // node_rd loads this cycle
					end else if (node_rd[KW+NA:NA+1] == key_q) begin
						state_q <= ST_DONE;
					end else if (node_rd[NA] && steps_q < NC'(NODES - 1)) begin
						state_q <= ST_CMP;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					strobe <= 1'b1;
					found <= hit_q;
					inserted <= nwe;
					full_res <= kind_q == chs_pkg::KIND_INSERT && !hit_q && !nwe;
					if (nwe)
						used_q <= used_q + 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ST_CMP alternates a read cycle (cmp_wait_q high) and a compare cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cmp_wait_q <= 1'b0;
		else
			cmp_wait_q <= (state_q == ST_NODE) ? head_rd[NA]
				: (state_q == ST_CMP) && !cmp_wait_q;
	end

	always_ff @(posedge clk) begin
		if (mreq.go) begin
			key_q <= key;
			kind_q <= kind;
		end
		if (mdone)
			bkt_q <= mrem[BA-1:0];
		case (state_q)
			ST_NODE: begin
				ptr_q <= head_rd[NA-1:0];
				steps_q <= '0;
				hit_q <= 1'b0;
			end
			ST_CMP: begin
				if (!cmp_wait_q) begin
					if (node_rd[KW+NA:NA+1] == key_q)
						hit_q <= 1'b1;
					ptr_q <= node_rd[NA-1:0];
					steps_q <= steps_q + 1'b1;
				end
			end
			default: ;
		endcase
	end
endmodule

// ===== rtl/chs_checker.sv =====
`include "chained_hash_set_core_macros.svh"
module chs_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic strobe,
	input logic found,
	input logic inserted,
	input logic full_res
);
	`CHS_ASSERT_IMP(a_one_flag, clk, arst_n, strobe, !(inserted && (found || full_res)))
	`CHS_ASSERT_IMP(a_no_full_hit, clk, arst_n, strobe, !(found && full_res))
	`CHS_ASSERT_NEXT(a_busy_after_start, clk, arst_n, start && !busy, busy)
	`CHS_ASSERT_IMP(a_strobe_busy, clk, arst_n, strobe, !$past(start && !busy))
endmodule

bind chained_hash_set_core chs_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .strobe(strobe),
	.found(found), .inserted(inserted), .full_res(full_res)
);
